@@ rtl/bhs_pkg.sv @@
// Shared types, register codes and helper functions for the ball-in-hexagon step core.
// No dependencies. Used by every module of the block.
package bhs_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_GRAVITY     = 3'd0;
  localparam logic [2:0] CFG_ELASTICITY  = 3'd1;
  localparam logic [2:0] CFG_HEX_RADIUS  = 3'd2;
  localparam logic [2:0] CFG_BALL_RADIUS = 3'd3;
  localparam logic [2:0] CFG_SPIN_RATE   = 3'd4;
  localparam logic [2:0] CFG_CENTER_X    = 3'd5;
  localparam logic [2:0] CFG_CENTER_Y    = 3'd6;

  localparam logic signed [33:0] S24_MAX = 34'sd8388607;
  localparam logic signed [33:0] S24_MIN = -34'sd8388608;

  // pi/2 in Q30 for the sine table build
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // operand widths of the shared multiplier
  localparam int unsigned MUL_A_W = 29;
  localparam int unsigned MUL_B_W = 18;
  localparam int unsigned ACC_W   = 48;

  typedef enum logic [4:0] {
    S_IDLE, S_SPIN, S_GRAV, S_VELY, S_POSX, S_POSY, S_APO,
    E_LOOK, E_DOT1, E_DOT2, E_CMP, E_V1, E_DOTW, E_K, E_KW,
    E_VX, E_VY, E_PX, E_PY, E_PYW, S_DONE
  } seq_state_e;

  typedef enum logic [3:0] {
    A_ZERO, A_SPIN, A_GRAV, A_VELX, A_VELY, A_HEX, A_RX, A_RY,
    A_DOT2, A_KREG, A_PUSH
  } opa_e;

  typedef enum logic [2:0] {
    B_ZERO, B_DT, B_COS_APO, B_NX, B_NY, B_ELAST
  } opb_e;

  typedef enum logic [3:0] {
    W_NONE, W_SPIN, W_VELY, W_POSX, W_POSY, W_APO, W_REL, W_DIST,
    W_DOT, W_K, W_VX, W_VY, W_PX, W_PY
  } wb_e;

  typedef struct packed {
    seq_state_e st;
    opa_e       a_sel;
    opb_e       b_sel;
    logic       acc_add;
    wb_e        wb;
    logic       edge_clr;
    logic       edge_step;
    logic       out_load;
  } ctrl_t;

  // saturate a wide signed sum to 24 bits
  function automatic logic signed [23:0] sat24(logic signed [33:0] v);
    logic signed [23:0] r;
    if (v > S24_MAX) begin
      r = 24'sh7FFFFF;
    end else if (v < S24_MIN) begin
      r = -24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // one quarter-wave sine table entry in Q16, evaluated at elaboration
  function automatic logic [16:0] sine_entry(int unsigned j, int unsigned bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x    = (64'(j) * HALF_PI_Q30) >> bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (int k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if ((k % 2) == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    return 17'((64'(sum) + 64'd8192) >> 14);
  endfunction

endpackage

@@ rtl/bhs_if.sv @@
// Handshake channels of the step core: tick words in, step result words out.
// No dependencies.
interface bhs_tick_if;
  logic        valid;
  logic        ready;
  logic [15:0] tick_time;
  modport source (output valid, output tick_time, input ready);
  modport sink   (input valid, input tick_time, output ready);
endinterface

interface bhs_step_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] ball_x;
  logic signed [23:0] ball_y;
  logic signed [23:0] speed_x;
  logic signed [23:0] speed_y;
  logic [15:0]        spin_now;
  logic [5:0]         hit_mask;
  modport source (output valid, output ball_x, output ball_y, output speed_x,
                  output speed_y, output spin_now, output hit_mask, input ready);
  modport sink   (input valid, input ball_x, input ball_y, input speed_x,
                  input speed_y, input spin_now, input hit_mask, output ready);
endinterface

@@ rtl/ball_in_spinning_hexagon_step_core.sv @@
// Ball in a spinning polygon, one tick per word, built around one shared 29x18 multiplier.
// Each tick runs the spin, gravity and position update, one distance check per edge and
// the bounce math for each edge hit, all on the multiply-accumulate unit and its sequencer.
// A new tick is taken only while idle; a result waits until the output register is free.
// Reset: config, state, sequencer and output valid only; no clearing pass is needed.
// Depends on bhs_pkg, bhs_if, bhs_sine_rom, bhs_mac and bhs_ctrl.
module ball_in_spinning_hexagon_step_core #(
  parameter int unsigned EDGE_COUNT      = 6,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [23:0]  cfg_data_i,
  bhs_tick_if.sink     tick_i,
  bhs_step_if.source   step_o
);
  import bhs_pkg::*;

  localparam int unsigned EW      = $clog2(EDGE_COUNT);
  localparam int unsigned APO_ANG = 32768 / EDGE_COUNT;
  localparam int unsigned APO_IDX = (16384 - APO_ANG) >> (14 - SINE_TABLE_BITS);
  localparam logic [16:0] COS_APO = sine_entry(APO_IDX, SINE_TABLE_BITS);

  // configuration registers
  logic [23:0]        grav_q;
  logic [15:0]        elast_q;
  logic [19:0]        hex_q;
  logic [19:0]        br_q;
  logic signed [15:0] spin_rate_q;
  logic signed [23:0] cx_q, cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q      <= 24'd76800;
      elast_q     <= 16'd52429;
      hex_q       <= 20'd51200;
      br_q        <= 20'd2560;
      spin_rate_q <= 16'sd5461;
      cx_q        <= 24'sd102400;
      cy_q        <= 24'sd76800;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRAVITY:     grav_q      <= cfg_data_i;
        CFG_ELASTICITY:  elast_q     <= cfg_data_i[15:0];
        CFG_HEX_RADIUS:  hex_q       <= cfg_data_i[19:0];
        CFG_BALL_RADIUS: br_q        <= cfg_data_i[19:0];
        CFG_SPIN_RATE:   spin_rate_q <= cfg_data_i[15:0];
        CFG_CENTER_X:    cx_q        <= cfg_data_i;
        CFG_CENTER_Y:    cy_q        <= cfg_data_i;
        default:         grav_q      <= grav_q;
      endcase
    end
  end

  ctrl_t ctrl;
  logic  start, hit, last_edge, out_free;

  // physics state and per-step working registers
  logic signed [23:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic signed [23:0] vel_x_q, vel_x_d, vel_y_q, vel_y_d;
  logic [15:0]        spin_q, spin_d;
  logic [15:0]        dt_q;
  logic [5:0]         hits_q, hits_d;
  logic [EW-1:0]      edge_q, edge_d;
  logic signed [20:0] apo_q;
  logic signed [24:0] rx_q, ry_q;
  logic signed [27:0] dot_q;
  logic signed [28:0] k_q, push_q;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [31:0]        rnd;
  logic signed [17:0]        nx, ny;
  logic signed [32:0]        edge_dist;
  logic [15:0]               mid_tbl [EDGE_COUNT];

  assign start     = tick_i.valid && tick_i.ready;
  assign out_free  = !step_o.valid || step_o.ready;
  assign last_edge = (edge_q == EW'(EDGE_COUNT - 1));
  assign tick_i.ready = (ctrl.st == S_IDLE);

  // mid-edge angle offsets
  for (genvar g = 0; g < EDGE_COUNT; g++) begin : g_mid
    assign mid_tbl[g] = 16'(((2 * g + 1) * 32768) / EDGE_COUNT);
  end

  bhs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .hit_i       (hit),
    .last_edge_i (last_edge),
    .out_free_i  (out_free),
    .ctrl_o      (ctrl)
  );

  bhs_sine_rom #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_rom (
    .clk_i (clk_i),
    .ang_i (spin_q + mid_tbl[edge_q]),
    .nx_o  (nx),
    .ny_o  (ny)
  );

  // multiplier operand select
  always_comb begin
    case (ctrl.a_sel)
      A_SPIN:  mul_a = MUL_A_W'(spin_rate_q);
      A_GRAV:  mul_a = {5'd0, grav_q};
      A_VELX:  mul_a = MUL_A_W'(vel_x_q);
      A_VELY:  mul_a = MUL_A_W'(vel_y_q);
      A_HEX:   mul_a = {9'd0, hex_q};
      A_RX:    mul_a = MUL_A_W'(rx_q);
      A_RY:    mul_a = MUL_A_W'(ry_q);
      A_DOT2:  mul_a = {dot_q, 1'b0};
      A_KREG:  mul_a = k_q;
      A_PUSH:  mul_a = push_q;
      default: mul_a = '0;
    endcase
    case (ctrl.b_sel)
      B_DT:      mul_b = {2'd0, dt_q};
      B_COS_APO: mul_b = {1'b0, COS_APO};
      B_NX:      mul_b = nx;
      B_NY:      mul_b = ny;
      B_ELAST:   mul_b = {2'd0, elast_q};
      default:   mul_b = '0;
    endcase
  end

  bhs_mac u_mac (
    .clk_i     (clk_i),
    .a_i       (mul_a),
    .b_i       (mul_b),
    .acc_add_i (ctrl.acc_add),
    .rnd_o     (rnd)
  );

  // edge distance test against the ball radius
  assign edge_dist = 33'(apo_q) + 33'(rnd);
  assign hit  = (ctrl.st == E_CMP) && (edge_dist < $signed({13'd0, br_q}));

  // state writeback from the rounded product
  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    vel_x_d = vel_x_q;
    vel_y_d = vel_y_q;
    spin_d  = spin_q;
    hits_d  = hits_q;
    edge_d  = edge_q;
    case (ctrl.wb)
      W_SPIN: spin_d  = spin_q + rnd[15:0];
      W_VELY: vel_y_d = sat24(34'(vel_y_q) + 34'(rnd));
      W_POSX: pos_x_d = sat24(34'(pos_x_q) + 34'(rnd));
      W_POSY: pos_y_d = sat24(34'(pos_y_q) + 34'(rnd));
      W_VX:   vel_x_d = sat24(34'(vel_x_q) - 34'(rnd));
      W_VY:   vel_y_d = sat24(34'(vel_y_q) - 34'(rnd));
      W_PX:   pos_x_d = sat24(34'(pos_x_q) + 34'(rnd));
      W_PY:   pos_y_d = sat24(34'(pos_y_q) + 34'(rnd));
      default: spin_d = spin_q;
    endcase
    // record which edges bounced, one hits bit for each edge index from 0 to 5
    if (hit) begin
      for (int h = 0; h < 6; h++) begin
        if (32'(edge_q) == h) begin
          hits_d[h] = 1'b1;
        end
      end
    end
    if (start) begin
      hits_d = '0;
    end
    if (ctrl.edge_clr) begin
      edge_d = '0;
    end else if (ctrl.edge_step && !last_edge) begin
      edge_d = edge_q + EW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= 24'sd102400;
      pos_y_q <= 24'sd51200;
      vel_x_q <= '0;
      vel_y_q <= '0;
      spin_q  <= '0;
      hits_q  <= '0;
      edge_q  <= '0;
    end else begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      vel_x_q <= vel_x_d;
      vel_y_q <= vel_y_d;
      spin_q  <= spin_d;
      hits_q  <= hits_d;
      edge_q  <= edge_d;
    end
  end

  // working operands
  always_ff @(posedge clk_i) begin
    if (start) begin
      dt_q <= tick_i.tick_time;
    end
    if (ctrl.wb == W_APO) begin
      apo_q <= rnd[20:0];
    end
    if (ctrl.wb == W_REL) begin
      rx_q <= 25'(pos_x_q) - 25'(cx_q);
      ry_q <= 25'(pos_y_q) - 25'(cy_q);
    end
    if (ctrl.wb == W_DIST) begin
      push_q <= 29'($signed({13'd0, br_q}) - edge_dist);
    end
    if (ctrl.wb == W_DOT) begin
      dot_q <= rnd[27:0];
    end
    if (ctrl.wb == W_K) begin
      k_q <= rnd[28:0];
    end
  end

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_o.valid <= 1'b0;
    end else if (ctrl.out_load) begin
      step_o.valid <= 1'b1;
    end else if (step_o.ready) begin
      step_o.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      step_o.ball_x   <= pos_x_q;
      step_o.ball_y   <= pos_y_q;
      step_o.speed_x  <= vel_x_q;
      step_o.speed_y  <= vel_y_q;
      step_o.spin_now <= spin_q;
      step_o.hit_mask <= hits_q;
    end
  end

endmodule

@@ rtl/bhs_sine_rom.sv @@
// Quarter-wave sine table with registered inward normal (-cos, -sin) lookup.
// Depends on bhs_pkg for the table entry function.
module bhs_sine_rom #(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic               clk_i,
  input  logic [15:0]        ang_i,
  output logic signed [17:0] nx_o,
  output logic signed [17:0] ny_o
);
  import bhs_pkg::*;

  localparam int unsigned TBL = (1 << SINE_TABLE_BITS) + 1;
  localparam int unsigned IW  = SINE_TABLE_BITS + 1;
  localparam int unsigned SH  = 14 - SINE_TABLE_BITS;

  logic [16:0] rom [TBL];

  // constant table built at elaboration
  for (genvar g = 0; g < TBL; g++) begin : g_rom
    assign rom[g] = sine_entry(g, SINE_TABLE_BITS);
  end

  logic [15:0]        cang;
  logic [14:0]        rs, rc;
  logic [IW-1:0]      is, ic;
  logic [16:0]        ms, mc;
  logic signed [17:0] ny_d, nx_d;

  // fold angle into first quadrant and read both magnitudes
  always_comb begin
    cang = ang_i + 16'd16384;
    rs   = {1'b0, ang_i[13:0]};
    rc   = {1'b0, cang[13:0]};
    if (ang_i[14]) begin
      rs = 15'd16384 - rs;
    end
    if (cang[14]) begin
      rc = 15'd16384 - rc;
    end
    is   = IW'(rs >> SH);
    ic   = IW'(rc >> SH);
    ms   = rom[is];
    mc   = rom[ic];
    ny_d = ang_i[15] ? $signed({1'b0, ms}) : -$signed({1'b0, ms});
    nx_d = cang[15]  ? $signed({1'b0, mc}) : -$signed({1'b0, mc});
  end

  always_ff @(posedge clk_i) begin
    nx_o <= nx_d;
    ny_o <= ny_d;
  end

endmodule

@@ rtl/bhs_mac.sv @@
// Shared multiply-accumulate unit with round-half-up Q16 result.
// Depends on bhs_pkg for operand widths.
module bhs_mac (
  input  logic                          clk_i,
  input  logic signed [bhs_pkg::MUL_A_W-1:0] a_i,
  input  logic signed [bhs_pkg::MUL_B_W-1:0] b_i,
  input  logic                          acc_add_i,
  output logic signed [31:0]            rnd_o
);
  import bhs_pkg::*;

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] biased;

  // product plus optional running sum
  always_comb begin
    prod  = ACC_W'(a_i * b_i);
    acc_d = (acc_add_i ? acc_q : '0) + prod;
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // floor(acc / 65536 + 1/2)
  assign biased = acc_q + ACC_W'(32768);
  assign rnd_o  = biased[47:16];

endmodule

@@ rtl/bhs_ctrl.sv @@
// Step sequencer: walks the update, the edge checks and the bounce math.
// Depends on bhs_pkg for state and control types.
module bhs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           hit_i,
  input  logic           last_edge_i,
  input  logic           out_free_i,
  output bhs_pkg::ctrl_t ctrl_o
);
  import bhs_pkg::*;

  seq_state_e st_q, st_d;

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: if (start_i) st_d = S_SPIN;
      S_SPIN: st_d = S_GRAV;
      S_GRAV: st_d = S_VELY;
      S_VELY: st_d = S_POSX;
      S_POSX: st_d = S_POSY;
      S_POSY: st_d = S_APO;
      S_APO:  st_d = E_LOOK;
      E_LOOK: st_d = E_DOT1;
      E_DOT1: st_d = E_DOT2;
      E_DOT2: st_d = E_CMP;
      E_CMP: begin
        if (hit_i) begin
          st_d = E_V1;
        end else if (last_edge_i) begin
          st_d = S_DONE;
        end else begin
          st_d = E_LOOK;
        end
      end
      E_V1:   st_d = E_DOTW;
      E_DOTW: st_d = E_K;
      E_K:    st_d = E_KW;
      E_KW:   st_d = E_VX;
      E_VX:   st_d = E_VY;
      E_VY:   st_d = E_PX;
      E_PX:   st_d = E_PY;
      E_PY:   st_d = E_PYW;
      E_PYW:  st_d = last_edge_i ? S_DONE : E_LOOK;
      S_DONE: if (out_free_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  // control outputs per step
  always_comb begin
    ctrl_o           = '0;
    ctrl_o.st        = st_q;
    ctrl_o.a_sel     = A_ZERO;
    ctrl_o.b_sel     = B_ZERO;
    ctrl_o.wb        = W_NONE;
    case (st_q)
      S_SPIN: begin
        ctrl_o.a_sel = A_SPIN; ctrl_o.b_sel = B_DT;
      end
      S_GRAV: begin
        ctrl_o.wb = W_SPIN; ctrl_o.a_sel = A_GRAV; ctrl_o.b_sel = B_DT;
      end
      S_VELY: begin
        ctrl_o.wb = W_VELY; ctrl_o.a_sel = A_VELX; ctrl_o.b_sel = B_DT;
      end
      S_POSX: begin
        ctrl_o.wb = W_POSX; ctrl_o.a_sel = A_VELY; ctrl_o.b_sel = B_DT;
      end
      S_POSY: begin
        ctrl_o.wb = W_POSY; ctrl_o.a_sel = A_HEX; ctrl_o.b_sel = B_COS_APO;
      end
      S_APO: begin
        ctrl_o.wb = W_APO; ctrl_o.edge_clr = 1'b1;
      end
      E_LOOK: ctrl_o.wb = W_REL;
      E_DOT1: begin
        ctrl_o.a_sel = A_RX; ctrl_o.b_sel = B_NX;
      end
      E_DOT2: begin
        ctrl_o.a_sel = A_RY; ctrl_o.b_sel = B_NY; ctrl_o.acc_add = 1'b1;
      end
      E_CMP: begin
        ctrl_o.wb = W_DIST; ctrl_o.a_sel = A_VELX; ctrl_o.b_sel = B_NX;
        ctrl_o.edge_step = !hit_i;
      end
      E_V1: begin
        ctrl_o.a_sel = A_VELY; ctrl_o.b_sel = B_NY; ctrl_o.acc_add = 1'b1;
      end
      E_DOTW: ctrl_o.wb = W_DOT;
      E_K: begin
        ctrl_o.a_sel = A_DOT2; ctrl_o.b_sel = B_ELAST;
      end
      E_KW: ctrl_o.wb = W_K;
      E_VX: begin
        ctrl_o.a_sel = A_KREG; ctrl_o.b_sel = B_NX;
      end
      E_VY: begin
        ctrl_o.wb = W_VX; ctrl_o.a_sel = A_KREG; ctrl_o.b_sel = B_NY;
      end
      E_PX: begin
        ctrl_o.wb = W_VY; ctrl_o.a_sel = A_PUSH; ctrl_o.b_sel = B_NX;
      end
      E_PY: begin
        ctrl_o.wb = W_PX; ctrl_o.a_sel = A_PUSH; ctrl_o.b_sel = B_NY;
      end
      E_PYW: begin
        ctrl_o.wb = W_PY; ctrl_o.edge_step = 1'b1;
      end
      S_DONE: ctrl_o.out_load = out_free_i;
      default: ctrl_o.wb = W_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

endmodule
